### rtl/gmd_pkg.sv
// Shared constants, types and the tangent table for the gradient magnitude/direction block.
`default_nettype none

package gmd_pkg;

    // Field widths
    localparam int GRAD_WIDTH  = 16;
    localparam int MAG_WIDTH   = 15;
    localparam int ANG_WIDTH   = 9;
    localparam int SQ_WIDTH    = 2 * GRAD_WIDTH;

    // Octant search: tangents of 1..44 degrees with TAN_FRAC fraction bits
    localparam int TAN_FRAC    = 47;
    localparam int SEARCH_BITS = 6;
    localparam int TAN_ENTRIES = 2 ** SEARCH_BITS;
    localparam int OCTANT_MAX  = 44;
    localparam int PROD_WIDTH  = TAN_FRAC + GRAD_WIDTH;

    // Pipeline depths of the two datapaths; the core runs both at the longer one
    localparam int MAG_DEPTH   = GRAD_WIDTH + 2;
    localparam int ANG_DEPTH   = 2 * SEARCH_BITS;
    localparam int CORE_DEPTH  = (MAG_DEPTH > ANG_DEPTH) ? MAG_DEPTH : ANG_DEPTH;

    localparam logic [MAG_WIDTH-1:0] MAG_MAX = '1;

    localparam logic [ANG_WIDTH-1:0] DEG_45  = ANG_WIDTH'(45);
    localparam logic [ANG_WIDTH-1:0] DEG_89  = ANG_WIDTH'(89);
    localparam logic [ANG_WIDTH-1:0] DEG_90  = ANG_WIDTH'(90);
    localparam logic [ANG_WIDTH-1:0] DEG_179 = ANG_WIDTH'(179);
    localparam logic [ANG_WIDTH-1:0] DEG_180 = ANG_WIDTH'(180);
    localparam logic [ANG_WIDTH-1:0] DEG_359 = ANG_WIDTH'(359);
    localparam logic [ANG_WIDTH-1:0] DEG_360 = ANG_WIDTH'(360);

    typedef logic [GRAD_WIDTH-1:0]  grad_abs_t;
    typedef logic [TAN_FRAC-1:0]    tan_t;
    typedef logic [SEARCH_BITS-1:0] deg_idx_t;
    typedef logic [TAN_ENTRIES-1:0][TAN_FRAC-1:0] tan_table_t;

    // Classification of the folded vector, carried alongside the search
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic both_zero;
        logic x_zero;
        logic y_zero;
        logic equal;
        logic swap;
    } octant_t;

    // Q60 fixed point used only while building the table
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_Q60 = PI_Q60 / 180;
    localparam logic [63:0] ONE_Q60 = 64'h1 << 60;

    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'h0, a} * {64'h0, b};
        return p[123:60];
    endfunction

    // tan(d degrees) in Q47 for d = 0..44; codes above 44 read as all ones so
    // that a compare against them fails unless mn equals mx.
    function automatic tan_table_t build_tan_table();
        tan_table_t  t;
        logic [63:0] x, x2, x3, x4, x5, x6, x7, x8, x9, x10;
        logic [63:0] s1, c1, s, c, sn, rem;
        tan_t        q;
        x   = DEG_Q60;
        x2  = mul_q60(x, x);
        x3  = mul_q60(x2, x);
        x4  = mul_q60(x2, x2);
        x5  = mul_q60(x4, x);
        x6  = mul_q60(x4, x2);
        x7  = mul_q60(x6, x);
        x8  = mul_q60(x4, x4);
        x9  = mul_q60(x8, x);
        x10 = mul_q60(x8, x2);
        s1  = x - x3 / 6 + x5 / 120 - x7 / 5040 + x9 / 362880;
        c1  = ONE_Q60 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320 - x10 / 3628800;
        for (int d = 0; d < TAN_ENTRIES; d++) begin
            t[d] = '1;
        end
        t[0] = '0;
        s = s1;
        c = c1;
        for (int d = 1; d <= OCTANT_MAX; d++) begin
            rem = s;
            q   = '0;
            for (int i = 0; i < TAN_FRAC; i++) begin
                rem = rem << 1;
                q   = {q[TAN_FRAC-2:0], 1'b0};
                if (rem >= c) begin
                    rem  = rem - c;
                    q[0] = 1'b1;
                end
            end
            t[d] = q;
            // rotate by one degree
            sn = mul_q60(s, c1) + mul_q60(c, s1);
            c  = mul_q60(c, c1) - mul_q60(s, s1);
            s  = sn;
        end
        return t;
    endfunction

    localparam tan_table_t TAN_TABLE = build_tan_table();

endpackage

`default_nettype wire

### rtl/gradient_magnitude_direction_top.sv
// Sobel gradient magnitude and direction, one pixel request per clock unless the output stalls.
// Pipeline: one fold stage, the square-root pipeline (one result bit per stage) that sets the
// depth, and the output register.
// Throughput: one request per cycle while the output is not stalled; stages with no valid data fill in while it stalls.
// Reset (aresetn low, synchronous) clears only the stage valid bits; data registers keep junk.
`default_nettype none

module gradient_magnitude_direction_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gmd_pkg::GRAD_WIDTH-1:0] s_horiz_response,
    input  logic signed [gmd_pkg::GRAD_WIDTH-1:0] s_vert_response,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gmd_pkg::MAG_WIDTH-1:0]        m_magnitude,
    output logic [gmd_pkg::ANG_WIDTH-1:0]        m_angle_degrees
);
    import gmd_pkg::*;

    // Stage 0 is the fold, 1..CORE_DEPTH the core datapaths, LAST the output register.
    localparam int LAST = CORE_DEPTH + 1;

    logic [LAST:0] valid_reg;
    logic [LAST:0] valid_next;
    logic [LAST:0] adv;

    // Fold stage signals
    logic      xneg;
    logic      yneg;
    grad_abs_t ax_c;
    grad_abs_t ay_c;
    octant_t   side_c;

    grad_abs_t ax_reg;
    grad_abs_t ay_reg;
    grad_abs_t mn_reg;
    grad_abs_t mx_reg;
    octant_t   side_reg;

    // Core outputs
    grad_abs_t root;
    deg_idx_t  cnt;
    octant_t   side_out;

    // Output composition
    logic [ANG_WIDTH-1:0] cnt_w;
    logic [ANG_WIDTH-1:0] bf;
    logic [ANG_WIDTH-1:0] angle_next;
    logic [MAG_WIDTH-1:0] magnitude_next;
    logic                 exact;

    logic [MAG_WIDTH-1:0] magnitude_reg;
    logic [ANG_WIDTH-1:0] angle_reg;

    // ---------------------------------------------------------------------
    // Flow control: a stage advances when it is empty or the next one advances.
    // The output register frees itself when the consumer takes the request.
    // ---------------------------------------------------------------------
    assign adv[LAST] = !valid_reg[LAST] || m_ready;

    genvar i;
    for (i = 0; i < LAST; i++) begin : g_adv
        assign adv[i] = !valid_reg[i] || adv[i+1];
    end

    assign valid_next[0] = adv[0] ? s_valid : valid_reg[0];
    for (i = 1; i <= LAST; i++) begin : g_valid
        assign valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[LAST];

    // ---------------------------------------------------------------------
    // Fold: take absolute values (the most negative code maps to 2^(W-1)),
    // order them into min/max and classify the special directions.
    // ---------------------------------------------------------------------
    assign xneg = s_horiz_response[GRAD_WIDTH-1];
    assign yneg = s_vert_response[GRAD_WIDTH-1];
    assign ax_c = xneg ? grad_abs_t'(~s_horiz_response) + grad_abs_t'(1)
                       : grad_abs_t'(s_horiz_response);
    assign ay_c = yneg ? grad_abs_t'(~s_vert_response) + grad_abs_t'(1)
                       : grad_abs_t'(s_vert_response);

    always_comb begin
        side_c.xneg      = xneg;
        side_c.yneg      = yneg;
        side_c.x_zero    = (ax_c == '0);
        side_c.y_zero    = (ay_c == '0);
        side_c.both_zero = (ax_c == '0) && (ay_c == '0);
        side_c.equal     = (ax_c == ay_c);
        side_c.swap      = (ax_c < ay_c);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ax_reg   <= ax_c;
            ay_reg   <= ay_c;
            mn_reg   <= side_c.swap ? ax_c : ay_c;
            mx_reg   <= side_c.swap ? ay_c : ax_c;
            side_reg <= side_c;
        end
    end

    // ---------------------------------------------------------------------
    // Core datapaths, both CORE_DEPTH stages long and advanced in lockstep.
    // ---------------------------------------------------------------------
    gmd_magnitude u_magnitude (
        .aclk (aclk),
        .adv  (adv[CORE_DEPTH:1]),
        .ax   (ax_reg),
        .ay   (ay_reg),
        .root (root)
    );

    gmd_octant_search u_octant_search (
        .aclk     (aclk),
        .adv      (adv[CORE_DEPTH:1]),
        .mn       (mn_reg),
        .mx       (mx_reg),
        .side_in  (side_reg),
        .cnt      (cnt),
        .side_out (side_out)
    );

    // ---------------------------------------------------------------------
    // Output: saturate the magnitude, unfold the base angle into 0..359.
    // When the vector is not on an axis or diagonal the truncated angle of a
    // mirrored quadrant sits one degree below the mirrored base.
    // ---------------------------------------------------------------------
    assign magnitude_next = (root > GRAD_WIDTH'(MAG_MAX)) ? MAG_MAX : MAG_WIDTH'(root);

    always_comb begin
        cnt_w = ANG_WIDTH'(cnt);
        exact = side_out.x_zero || side_out.y_zero || side_out.equal;

        if (side_out.x_zero) begin
            bf = '0;
        end else if (side_out.y_zero) begin
            bf = DEG_90;
        end else if (side_out.equal) begin
            bf = DEG_45;
        end else if (side_out.swap) begin
            bf = cnt_w;
        end else begin
            bf = DEG_89 - cnt_w;
        end

        if (side_out.both_zero) begin
            angle_next = '0;
        end else if (!side_out.xneg && !side_out.yneg) begin
            angle_next = bf;
        end else if (!side_out.xneg) begin
            angle_next = exact ? DEG_180 - bf : DEG_179 - bf;
        end else if (side_out.yneg) begin
            angle_next = DEG_180 + bf;
        end else begin
            angle_next = exact ? DEG_360 - bf : DEG_359 - bf;
        end
    end

    // Hold the result until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (adv[LAST]) begin
            magnitude_reg <= magnitude_next;
            angle_reg     <= angle_next;
        end
    end

    assign m_magnitude     = magnitude_reg;
    assign m_angle_degrees = angle_reg;

endmodule

`default_nettype wire

### rtl/gmd_magnitude.sv
// Pipelined squares, sum and bit-per-stage integer square root.
`default_nettype none

module gmd_magnitude (
    input  logic                                 aclk,
    input  logic [gmd_pkg::CORE_DEPTH-1:0]       adv,
    input  gmd_pkg::grad_abs_t                   ax,
    input  gmd_pkg::grad_abs_t                   ay,
    output gmd_pkg::grad_abs_t                   root
);
    import gmd_pkg::*;

    logic [SQ_WIDTH-1:0] sqx_reg;
    logic [SQ_WIDTH-1:0] sqy_reg;
    logic [SQ_WIDTH-1:0] rem_reg  [1:CORE_DEPTH-1];
    grad_abs_t           root_reg [1:CORE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            sqx_reg <= SQ_WIDTH'(ax) * SQ_WIDTH'(ax);
            sqy_reg <= SQ_WIDTH'(ay) * SQ_WIDTH'(ay);
        end
    end

    genvar k;
    for (k = 1; k < CORE_DEPTH; k++) begin : g_stage
        logic [SQ_WIDTH-1:0] rem_next;
        grad_abs_t           root_next;

        if (k == 1) begin : g_sum
            assign rem_next  = sqx_reg + sqy_reg;
            assign root_next = '0;
        end else if (k - 2 < GRAD_WIDTH) begin : g_step
            localparam int B = GRAD_WIDTH - 1 - (k - 2);
            logic [SQ_WIDTH:0] delta;
            logic              take;
            // (root + 2^B)^2 - root^2, root has no bits at or below B
            assign delta = ((SQ_WIDTH + 1)'(root_reg[k-1]) << (B + 1))
                         | ((SQ_WIDTH + 1)'(1) << (2 * B));
            assign take      = {1'b0, rem_reg[k-1]} >= delta;
            assign rem_next  = take ? rem_reg[k-1] - delta[SQ_WIDTH-1:0] : rem_reg[k-1];
            assign root_next = take ? (root_reg[k-1] | (grad_abs_t'(1) << B))
                                    : root_reg[k-1];
        end else begin : g_pass
            assign rem_next  = rem_reg[k-1];
            assign root_next = root_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[CORE_DEPTH-1];

endmodule

`default_nettype wire

### rtl/gmd_octant_search.sv
// Pipelined binary search of the base angle floor(atan(mn/mx)) against the tangent table.
`default_nettype none

module gmd_octant_search (
    input  logic                           aclk,
    input  logic [gmd_pkg::CORE_DEPTH-1:0] adv,
    input  gmd_pkg::grad_abs_t             mn,
    input  gmd_pkg::grad_abs_t             mx,
    input  gmd_pkg::octant_t               side_in,
    output gmd_pkg::deg_idx_t              cnt,
    output gmd_pkg::octant_t               side_out
);
    import gmd_pkg::*;

    grad_abs_t             mn_reg   [CORE_DEPTH];
    grad_abs_t             mx_reg   [CORE_DEPTH];
    deg_idx_t              cnt_reg  [CORE_DEPTH];
    logic [PROD_WIDTH-1:0] prod_reg [CORE_DEPTH];
    octant_t               side_reg [CORE_DEPTH];

    genvar k;
    for (k = 0; k < CORE_DEPTH; k++) begin : g_stage
        grad_abs_t             mn_prev;
        grad_abs_t             mx_prev;
        deg_idx_t              cnt_prev;
        logic [PROD_WIDTH-1:0] prod_prev;
        octant_t               side_prev;
        deg_idx_t              cnt_next;
        logic [PROD_WIDTH-1:0] prod_next;

        if (k == 0) begin : g_first
            assign mn_prev   = mn;
            assign mx_prev   = mx;
            assign cnt_prev  = '0;
            assign prod_prev = '0;
            assign side_prev = side_in;
        end else begin : g_chain
            assign mn_prev   = mn_reg[k-1];
            assign mx_prev   = mx_reg[k-1];
            assign cnt_prev  = cnt_reg[k-1];
            assign prod_prev = prod_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        if (k < ANG_DEPTH) begin : g_search
            localparam int J = k / 2;
            localparam deg_idx_t BIT = deg_idx_t'(1) << (SEARCH_BITS - 1 - J);
            deg_idx_t cand;
            assign cand = cnt_prev | BIT;
            if (k % 2 == 0) begin : g_mul
                // tan(cand) * mx, compared next stage
                assign prod_next = PROD_WIDTH'(TAN_TABLE[cand]) * PROD_WIDTH'(mx_prev);
                assign cnt_next  = cnt_prev;
            end else begin : g_cmp
                // keep the bit when tan(cand) <= mn/mx
                assign prod_next = prod_prev;
                assign cnt_next  = ({mn_prev, {TAN_FRAC{1'b0}}} >= prod_prev) ? cand
                                                                               : cnt_prev;
            end
        end else begin : g_pass
            assign prod_next = prod_prev;
            assign cnt_next  = cnt_prev;
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                mn_reg[k]   <= mn_prev;
                mx_reg[k]   <= mx_prev;
                cnt_reg[k]  <= cnt_next;
                prod_reg[k] <= prod_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign cnt      = cnt_reg[CORE_DEPTH-1];
    assign side_out = side_reg[CORE_DEPTH-1];

endmodule

`default_nettype wire

### test/tb_gradient_magnitude_direction_top.sv
// Self-checking testbench for the Sobel gradient magnitude and direction block.
`default_nettype none

module tb_gradient_magnitude_direction_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gmd_pkg::*;

    localparam int  RANDOM_REQUESTS = 750;
    localparam int  MAX_WAIT        = 11;
    localparam int  REPORT_LIMIT    = 10;
    // Longest quiet stretch of a correct run is one sender gap, the pipeline
    // latency and one receiver stall; allow a wide margin over that.
    localparam int  WATCHDOG_LIMIT  = 2000;
    localparam int  DRAIN_CYCLES    = CORE_DEPTH + 10;
    localparam int  SAT_LEVEL       = 32767;
    localparam real DEG_TO_RAD      = 3.14159265358979323846 / 180.0;

    // One pixel request: the two Sobel responses
    typedef struct {
        logic signed [GRAD_WIDTH-1:0] horiz;
        logic signed [GRAD_WIDTH-1:0] vert;
    } sobel_pair_t;

    // Expected gradient for one request, with its inputs kept for reporting
    typedef struct {
        logic signed [GRAD_WIDTH-1:0] horiz;
        logic signed [GRAD_WIDTH-1:0] vert;
        logic [MAG_WIDTH-1:0]         magnitude;
        logic [ANG_WIDTH-1:0]         angle;
    } gradient_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                         s_valid          = 1'b0;
    logic                         s_ready;
    logic signed [GRAD_WIDTH-1:0] s_horiz_response = '0;
    logic signed [GRAD_WIDTH-1:0] s_vert_response  = '0;
    logic                         m_valid;
    logic                         m_ready          = 1'b0;
    logic [MAG_WIDTH-1:0]         m_magnitude;
    logic [ANG_WIDTH-1:0]         m_angle_degrees;

    sobel_pair_t pending_pixels[$];
    gradient_t   expected_gradients[$];

    int error_count = 0;
    int idle_cycles = 0;
    int req_wait    = 0;
    int rsp_wait    = 0;
    bit req_burst   = 1'b0;
    bit rsp_burst   = 1'b0;

    gradient_magnitude_direction_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_horiz_response (s_horiz_response),
        .s_vert_response  (s_vert_response),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_magnitude      (m_magnitude),
        .m_angle_degrees  (m_angle_degrees)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Count a failure; print only the first few in full.
    task automatic note_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic push_pixel(int hx, int vy);
        sobel_pair_t p;
        p.horiz = GRAD_WIDTH'(hx);
        p.vert  = GRAD_WIDTH'(vy);
        pending_pixels.push_back(p);
    endtask

    // Compute the expected magnitude and direction of one pixel. The angle is
    // measured from the vertical response toward the horizontal one, floored
    // to whole degrees and wrapped into 0..359.
    function automatic gradient_t predict_gradient(logic signed [GRAD_WIDTH-1:0] hx,
                                                   logic signed [GRAD_WIDTH-1:0] vy);
        gradient_t g;
        longint    ax, ay, sq, root;
        int        base, ang, steps;
        bit        xneg, yneg, exact;
        real       lo, hi;
        g.horiz = hx;
        g.vert  = vy;
        xneg    = hx[GRAD_WIDTH-1];
        yneg    = vy[GRAD_WIDTH-1];
        ax      = xneg ? -longint'(hx) : longint'(hx);
        ay      = yneg ? -longint'(vy) : longint'(vy);

        // Integer square root: seed from the real root, then trim to the floor
        sq   = ax * ax + ay * ay;
        root = longint'($floor($sqrt(real'(sq))));
        while (root * root > sq) root--;
        while ((root + 1) * (root + 1) <= sq) root++;
        g.magnitude = (root > SAT_LEVEL) ? MAG_MAX : MAG_WIDTH'(root);

        if (ax == 0 && ay == 0) begin
            ang = 0;
        end else begin
            exact = 1'b1;
            if (ax == 0) begin
                base = 0;
            end else if (ay == 0) begin
                base = 90;
            end else if (ax == ay) begin
                base = 45;
            end else begin
                // Fold into the first octant and count whole degrees passed
                exact = 1'b0;
                lo    = real'((ax < ay) ? ax : ay);
                hi    = real'((ax < ay) ? ay : ax);
                steps = 0;
                for (int d = 1; d <= OCTANT_MAX; d++) begin
                    if (lo >= $tan(d * DEG_TO_RAD) * hi) steps++;
                end
                base = (ax < ay) ? steps : 89 - steps;
            end
            // Unfold into the quadrant; a non-integer angle loses one degree
            // when mirrored because the floor moves to the other side
            if (!xneg && !yneg)  ang = base;
            else if (!xneg)      ang = exact ? 180 - base : 179 - base;
            else if (yneg)       ang = 180 + base;
            else                 ang = exact ? 360 - base : 359 - base;
        end
        g.angle = ANG_WIDTH'(ang);
        return g;
    endfunction

    // Request driver: record the expectation of each accepted request, hold
    // a waiting request, then idle for the drawn gap before the next one.
    always @(posedge aclk) begin : request_driver
        sobel_pair_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            req_wait = $urandom_range(0, MAX_WAIT);
        end else begin
            if (s_valid && s_ready) begin
                expected_gradients.push_back(predict_gradient(s_horiz_response,
                                                              s_vert_response));
                // Switch now and then between gapped traffic and back-to-back bursts
                if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
                req_wait = req_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (s_valid && !s_ready) begin
                // hold the request and its payload until it is taken
            end else if (req_wait > 0) begin
                req_wait--;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                nxt = pending_pixels.pop_front();
                s_horiz_response <= nxt.horiz;
                s_vert_response  <= nxt.vert;
                s_valid          <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each accepted result against the oldest
    // expectation, then stall for the drawn number of cycles.
    always @(posedge aclk) begin : result_monitor
        gradient_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rsp_wait = $urandom_range(0, MAX_WAIT);
        end else begin
            if (m_valid && m_ready) begin
                if (expected_gradients.size() == 0) begin
                    note_error($sformatf("unexpected result mag=%0d ang=%0d",
                                         m_magnitude, m_angle_degrees));
                end else begin
                    want = expected_gradients.pop_front();
                    if (m_magnitude !== want.magnitude || m_angle_degrees !== want.angle) begin
                        note_error($sformatf(
                            "x=%0d y=%0d: expected mag=%0d ang=%0d, got mag=%0d ang=%0d",
                            want.horiz, want.vert, want.magnitude, want.angle,
                            m_magnitude, m_angle_degrees));
                    end
                end
                if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
                rsp_wait = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (rsp_wait > 0) begin
                rsp_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int mode, a, b, hx, vy;

        // Directed requests: zero vector, axes, diagonals, extremes, saturation
        push_pixel(0, 0);
        push_pixel(0, 5);
        push_pixel(0, -5);
        push_pixel(5, 0);
        push_pixel(-5, 0);
        push_pixel(7, 7);
        push_pixel(7, -7);
        push_pixel(-7, -7);
        push_pixel(-7, 7);
        push_pixel(32767, 32767);
        push_pixel(-32768, -32768);
        push_pixel(-32768, 0);
        push_pixel(0, -32768);
        push_pixel(-32768, 32767);
        push_pixel(23170, 23170);
        push_pixel(23171, -23171);
        push_pixel(1, 32767);
        push_pixel(32767, 1);
        push_pixel(-1, -32767);
        push_pixel(3, 4);
        push_pixel(-3, 4);
        push_pixel(3, -4);
        push_pixel(-3, -4);
        push_pixel(12345, -23456);
        push_pixel(-1, 1);

        // Random requests from a mix of shapes
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            mode = $urandom_range(0, 9);
            if (mode <= 3) begin
                // full range, every bit toggles
                hx = int'($urandom()) & 32'hFFFF;
                vy = int'($urandom()) & 32'hFFFF;
            end else if (mode <= 5) begin
                // small responses, where degrees are coarse
                hx = $urandom_range(0, 128) - 64;
                vy = $urandom_range(0, 128) - 64;
            end else if (mode == 6) begin
                // exact diagonals
                a  = $urandom_range(0, 32767);
                hx = $urandom_range(0, 1) ? -a : a;
                vy = $urandom_range(0, 1) ? -a : a;
            end else if (mode == 7) begin
                // on an axis
                a  = int'($urandom()) & 32'hFFFF;
                hx = $urandom_range(0, 1) ? a : 0;
                vy = (hx == 0) ? a : 0;
            end else if (mode == 8) begin
                // close to a diagonal
                a  = $urandom_range(4, 32763);
                b  = a + $urandom_range(0, 8) - 4;
                hx = $urandom_range(0, 1) ? -a : a;
                vy = $urandom_range(0, 1) ? -b : b;
            end else begin
                // close to the saturation circle
                a  = $urandom_range(0, 32767);
                b  = int'($sqrt(real'(SAT_LEVEL) * SAT_LEVEL - real'(a) * a));
                b  = b + $urandom_range(0, 4) - 2;
                if (b > SAT_LEVEL) b = SAT_LEVEL;
                if (b < 0) b = 0;
                hx = $urandom_range(0, 1) ? -a : a;
                vy = $urandom_range(0, 1) ? -b : b;
            end
            push_pixel(hx, vy);
        end

        // Hold reset, then release it
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to go out and every result to come back
        while (pending_pixels.size() != 0 || s_valid) @(posedge aclk);
        while (expected_gradients.size() != 0) @(posedge aclk);
        // Let the pipeline drain so a stray extra result gets caught
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/gmd_pkg.sv
rtl/gmd_magnitude.sv
rtl/gmd_octant_search.sv
rtl/gradient_magnitude_direction_top.sv
test/tb_gradient_magnitude_direction_top.sv
